FILE: sv/hdu_pkg.sv
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types and constants for the half-duplex uart bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hdu_pkg;

   // receive ring geometry (one slot stays empty to tell full from empty)
   localparam int RING_DEPTH = 16;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   // frame and field widths
   localparam int FRAME_W = 10;
   localparam int BYTE_W  = 8;
   localparam int OP_W    = 3;
   localparam int FILL_W  = 4;
   localparam int TICK_W  = 8;

   // receiver bit position codes
   localparam logic [3:0] RX_WAIT  = 4'd15;
   localparam logic [3:0] RX_FIRST = 4'd0;
   localparam logic [3:0] RX_STOP  = 4'd8;

   // host operation codes
   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_READ   = 3'd2,
      OP_ARM    = 3'd3,
      OP_DISARM = 3'd4
   } op_type;

   // decoded command for one transaction, valid only in its execute cycle
   typedef struct packed {
      logic tick;
      logic load;
      logic read;
      logic arm;
      logic disarm;
   } cmd_type;

endpackage : hdu_pkg

`default_nettype wire

FILE: sv/half_duplex_uart_bit_engine.sv
// ----------------------------------------------------------------------------
// half_duplex_uart_bit_engine
// Single-wire 8N1 uart bit engine driven by an external bit tick, with a
// receive byte ring read by the host.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_stall| op, line_in, tx_byte
//   rsp     | out       | rsp_valid/rsp_stall| line_out, tx_busy, rx_armed,
//           |           |                    | read_valid, read_data, overflow,
//           |           |                    | fill_level, rx_tick_count
//
// One transaction per cycle while the result is not stalled; each passes the input
// register, then the state update together with the result register.
// The limit is the single shared state update per cycle in tx and rx.
// Synchronous active-high reset idles the line high, disarms receive and
// empties the ring; ring contents are not cleared.
// A stalled result holds both the result and the engine state; the input
// register keeps accepting while the result stage is free to move.
// ----------------------------------------------------------------------------
`default_nettype none

module half_duplex_uart_bit_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [hdu_pkg::OP_W-1:0]      req_op,
   input  wire logic                          req_line_in,
   input  wire logic [hdu_pkg::BYTE_W-1:0]    req_tx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_line_out,
   output logic                               rsp_tx_busy,
   output logic                               rsp_rx_armed,
   output logic                               rsp_read_valid,
   output logic [hdu_pkg::BYTE_W-1:0]         rsp_read_data,
   output logic                               rsp_overflow,
   output logic [hdu_pkg::FILL_W-1:0]         rsp_fill_level,
   output logic [hdu_pkg::TICK_W-1:0]         rsp_rx_tick_count
);

   logic                        in_valid_ff, in_valid_in;
   logic [hdu_pkg::OP_W-1:0]    in_op_ff;
   logic                        in_line_ff;
   logic [hdu_pkg::BYTE_W-1:0]  in_byte_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rd_valid_ff;
   logic [hdu_pkg::BYTE_W-1:0]  rd_data_ff;

   logic                        advance;
   logic                        fire;
   logic                        in_load;
   hdu_pkg::cmd_type            cmd;
   logic                        tx_busy;
   logic                        rd_valid;
   logic [hdu_pkg::BYTE_W-1:0]  rd_data;

   // pipeline handshake
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = advance && in_valid_ff;
   assign req_stall   = in_valid_ff && !advance;
   assign in_load     = req_valid && !req_stall;
   assign in_valid_in = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // op decode for the executing transaction
   always_comb begin
      cmd = '0;
      if (fire) begin
         unique case (in_op_ff)
            hdu_pkg::OP_TICK:   cmd.tick   = 1'b1;
            hdu_pkg::OP_LOAD:   cmd.load   = 1'b1;
            hdu_pkg::OP_READ:   cmd.read   = 1'b1;
            hdu_pkg::OP_ARM:    cmd.arm    = 1'b1;
            hdu_pkg::OP_DISARM: cmd.disarm = 1'b1;
            default:            cmd        = '0;
         endcase
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_op_ff   <= req_op;
         in_line_ff <= req_line_in;
         in_byte_ff <= req_tx_byte;
      end
   end

   // read result register
   always_ff @(posedge clock) begin
      if (fire) begin
         rd_valid_ff <= rd_valid;
         rd_data_ff  <= rd_data;
      end
   end

   hdu_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .tx_byte  (in_byte_ff),
      .tx_busy  (tx_busy),
      .line_out (rsp_line_out)
   );

   hdu_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .line_in    (in_line_ff),
      .tx_busy    (tx_busy),
      .rx_armed   (rsp_rx_armed),
      .rd_valid   (rd_valid),
      .rd_data    (rd_data),
      .overflow   (rsp_overflow),
      .fill_level (rsp_fill_level),
      .tick_count (rsp_rx_tick_count)
   );

   // engine state only moves with the result register, so it is the result
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_busy    = tx_busy;
   assign rsp_read_valid = rd_valid_ff;
   assign rsp_read_data  = rd_data_ff;

endmodule : half_duplex_uart_bit_engine

`default_nettype wire

FILE: sv/hdu_tx.sv
// ----------------------------------------------------------------------------
// hdu_tx
// Transmit frame shifter: forms the 8N1 frame on load and drives one bit per
// tick onto the wire.
// ----------------------------------------------------------------------------
`default_nettype none

module hdu_tx (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hdu_pkg::cmd_type              cmd,
   input  wire logic [hdu_pkg::BYTE_W-1:0]    tx_byte,
   output logic                               tx_busy,
   output logic                               line_out
);

   logic [hdu_pkg::FRAME_W-1:0] tx_shift_ff, tx_shift_in;
   logic                        tx_active_ff, tx_active_in;
   logic                        line_level_ff, line_level_in;

   // frame shift and busy control
   always_comb begin
      tx_shift_in   = tx_shift_ff;
      tx_active_in  = tx_active_ff;
      line_level_in = line_level_ff;
      if (cmd.tick && tx_active_ff) begin
         if (tx_shift_ff != '0) begin
            line_level_in = tx_shift_ff[0];
            tx_shift_in   = {1'b0, tx_shift_ff[hdu_pkg::FRAME_W-1:1]};
         end else begin
            tx_active_in = 1'b0;
         end
      end else if (cmd.load && !tx_active_ff) begin
         // stop bit, data lsb first, start bit
         tx_shift_in   = {1'b1, tx_byte, 1'b0};
         tx_active_in  = 1'b1;
         line_level_in = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff   <= '0;
         tx_active_ff  <= 1'b0;
         line_level_ff <= 1'b1;
      end else begin
         tx_shift_ff   <= tx_shift_in;
         tx_active_ff  <= tx_active_in;
         line_level_ff <= line_level_in;
      end
   end

   assign tx_busy  = tx_active_ff;
   assign line_out = line_level_ff;

endmodule : hdu_tx

`default_nettype wire

FILE: sv/hdu_rx.sv
// ----------------------------------------------------------------------------
// hdu_rx
// Receive sampler and byte ring: collects 8N1 frames from the wire on ticks
// and queues good bytes for host reads.
// ----------------------------------------------------------------------------
`default_nettype none

module hdu_rx (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hdu_pkg::cmd_type              cmd,
   input  wire logic                          line_in,
   input  wire logic                          tx_busy,
   output logic                               rx_armed,
   output logic                               rd_valid,
   output logic [hdu_pkg::BYTE_W-1:0]         rd_data,
   output logic                               overflow,
   output logic [hdu_pkg::FILL_W-1:0]         fill_level,
   output logic [hdu_pkg::TICK_W-1:0]         tick_count
);

   localparam int AW = hdu_pkg::RING_AW;
   localparam logic [AW-1:0] LAST = AW'(hdu_pkg::RING_DEPTH - 1);

   logic [hdu_pkg::BYTE_W-1:0] ring_ff [hdu_pkg::RING_DEPTH];

   logic                         rx_enable_ff, rx_enable_in;
   logic [3:0]                   bit_pos_ff, bit_pos_in;
   logic [hdu_pkg::BYTE_W-1:0]   rx_shift_ff, rx_shift_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [AW-1:0]                tail_ff, tail_in;
   logic                         lost_ff, lost_in;
   logic [hdu_pkg::TICK_W-1:0]   tick_ff, tick_in;

   logic          sample;
   logic          not_empty;
   logic          ring_we;
   logic [AW-1:0] head_nx;
   logic [AW-1:0] tail_nx;
   logic [AW:0]   diff;

   // ring pointer arithmetic
   assign head_nx   = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign tail_nx   = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
   assign not_empty = (head_ff != tail_ff);
   assign sample    = cmd.tick && !tx_busy && rx_enable_ff;

   // receiver, ring and host actions
   always_comb begin
      rx_enable_in = rx_enable_ff;
      bit_pos_in   = bit_pos_ff;
      rx_shift_in  = rx_shift_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      lost_in      = lost_ff;
      tick_in      = tick_ff;
      ring_we      = 1'b0;
      rd_valid     = 1'b0;
      rd_data      = '0;
      if (sample) begin
         tick_in = tick_ff + 1'b1;
         if (bit_pos_ff == hdu_pkg::RX_WAIT) begin
            // hunt for the start bit
            if (!line_in) begin
               bit_pos_in  = hdu_pkg::RX_FIRST;
               rx_shift_in = '0;
            end
         end else if (bit_pos_ff >= hdu_pkg::RX_STOP) begin
            // stop phase: keep the byte only on a high stop bit
            if (line_in) begin
               if (head_nx != tail_ff) begin
                  ring_we = 1'b1;
                  head_in = head_nx;
               end else begin
                  lost_in = 1'b1;
               end
            end
            bit_pos_in = hdu_pkg::RX_WAIT;
         end else begin
            rx_shift_in = {line_in, rx_shift_ff[hdu_pkg::BYTE_W-1:1]};
            bit_pos_in  = bit_pos_ff + 1'b1;
         end
      end
      if (cmd.read && not_empty) begin
         rd_valid = 1'b1;
         rd_data  = ring_ff[tail_ff];
         tail_in  = tail_nx;
      end
      if (cmd.arm) begin
         rx_enable_in = 1'b1;
         head_in      = '0;
         tail_in      = '0;
         bit_pos_in   = hdu_pkg::RX_WAIT;
      end
      if (cmd.disarm) begin
         rx_enable_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff <= 1'b0;
         bit_pos_ff   <= hdu_pkg::RX_WAIT;
         rx_shift_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         lost_ff      <= 1'b0;
         tick_ff      <= '0;
      end else begin
         rx_enable_ff <= rx_enable_in;
         bit_pos_ff   <= bit_pos_in;
         rx_shift_ff  <= rx_shift_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         lost_ff      <= lost_in;
         tick_ff      <= tick_in;
      end
   end

   // ring storage, no reset
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_ff[head_ff] <= rx_shift_ff;
      end
   end

   // bytes waiting, modulo ring depth
   assign diff = (head_ff >= tail_ff)
                 ? {1'b0, head_ff} - {1'b0, tail_ff}
                 : {1'b0, head_ff} + (AW+1)'(hdu_pkg::RING_DEPTH) - {1'b0, tail_ff};

   assign rx_armed   = rx_enable_ff;
   assign overflow   = lost_ff;
   assign fill_level = hdu_pkg::FILL_W'(diff);
   assign tick_count = tick_ff;

endmodule : hdu_rx

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the half-duplex uart bit engine. A queue-fed driver
// sends bit ticks and host actions, a behavioral copy of the engine works out
// each status transaction, and a monitor compares the results field by field
// under several idle and stall phases.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hdu_pkg::*;

   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int ITEM_TARGET    = 950;
   localparam int PHASES         = 4;
   localparam int BURST_FRAMES   = RING_DEPTH + 1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              line_in;
      logic [BYTE_W-1:0] tx_byte;
   } uart_cmd;

   typedef struct packed {
      logic              line_out;
      logic              tx_busy;
      logic              rx_armed;
      logic              read_valid;
      logic [BYTE_W-1:0] read_data;
      logic              overflow;
      logic [FILL_W-1:0] fill_level;
      logic [TICK_W-1:0] rx_tick_count;
   } uart_status;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op = OP_TICK;
   logic                req_line_in = 1'b1;
   logic [BYTE_W-1:0]   req_tx_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_line_out;
   logic                rsp_tx_busy;
   logic                rsp_rx_armed;
   logic                rsp_read_valid;
   logic [BYTE_W-1:0]   rsp_read_data;
   logic                rsp_overflow;
   logic [FILL_W-1:0]   rsp_fill_level;
   logic [TICK_W-1:0]   rsp_rx_tick_count;

   uart_cmd             pending_q[$];
   uart_status          status_q[$];
   uart_cmd             next_cmd;
   int                  queued_items = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_asked = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  quiet_cycles = 0;
   int                  fail_count = 0;

   // shadow copy of the engine state
   logic [FRAME_W-1:0]  eng_frame;
   logic                eng_sending;
   logic                eng_level;
   logic                eng_listening;
   logic [3:0]          eng_bitpos;
   logic [BYTE_W-1:0]   eng_rxbyte;
   logic [BYTE_W-1:0]   eng_ring [RING_DEPTH];
   logic [RING_AW-1:0]  eng_head;
   logic [RING_AW-1:0]  eng_tail;
   logic                eng_lost;
   logic [TICK_W-1:0]   eng_ticks;

   half_duplex_uart_bit_engine uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_line_in       (req_line_in),
      .req_tx_byte       (req_tx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_out      (rsp_line_out),
      .rsp_tx_busy       (rsp_tx_busy),
      .rsp_rx_armed      (rsp_rx_armed),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_overflow      (rsp_overflow),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_rx_tick_count (rsp_rx_tick_count)
   );

   // clock generation
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic rand_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic logic [RING_AW-1:0] ring_step(logic [RING_AW-1:0] ptr);
      return RING_AW'((int'(ptr) + 1) % RING_DEPTH);
   endfunction

   // ------------------------------------------------------------------------
   // engine prediction
   // ------------------------------------------------------------------------
   function automatic void reset_engine();
      eng_frame     = '0;
      eng_sending   = 1'b0;
      eng_level     = 1'b1;
      eng_listening = 1'b0;
      eng_bitpos    = RX_WAIT;
      eng_rxbyte    = '0;
      eng_head      = '0;
      eng_tail      = '0;
      eng_lost      = 1'b0;
      eng_ticks     = '0;
   endfunction

   // one receive sample: hunt for start, shift data lsb first, check stop
   function automatic void sample_line(logic level);
      logic [RING_AW-1:0] nxt;
      nxt = ring_step(eng_head);
      if (eng_bitpos == RX_WAIT) begin
         if (!level) begin
            eng_bitpos = RX_FIRST;
            eng_rxbyte = '0;
         end
      end else if (eng_bitpos >= RX_STOP) begin
         if (level) begin
            if (nxt != eng_tail) begin
               eng_ring[eng_head] = eng_rxbyte;
               eng_head = nxt;
            end else begin
               eng_lost = 1'b1;
            end
         end
         eng_bitpos = RX_WAIT;
      end else begin
         eng_rxbyte = {level, eng_rxbyte[BYTE_W-1:1]};
         eng_bitpos = eng_bitpos + 1'b1;
      end
   endfunction

   function automatic uart_status advance_engine(logic [OP_W-1:0] op, logic line_in,
                                                 logic [BYTE_W-1:0] tx_byte);
      uart_status s;
      s = '0;
      case (op)
         OP_TICK: begin
            // transmit has priority over receive sampling
            if (eng_sending) begin
               if (eng_frame != '0) begin
                  eng_level = eng_frame[0];
                  eng_frame = eng_frame >> 1;
               end else begin
                  eng_sending = 1'b0;
               end
            end else if (eng_listening) begin
               sample_line(line_in);
               eng_ticks = eng_ticks + 1'b1;
            end
         end
         OP_LOAD: begin
            if (!eng_sending) begin
               eng_frame   = {1'b1, tx_byte, 1'b0};
               eng_sending = 1'b1;
               eng_level   = 1'b1;
            end
         end
         OP_READ: begin
            if (eng_head != eng_tail) begin
               s.read_valid = 1'b1;
               s.read_data  = eng_ring[eng_tail];
               eng_tail     = ring_step(eng_tail);
            end
         end
         OP_ARM: begin
            eng_listening = 1'b1;
            eng_head      = '0;
            eng_tail      = '0;
            eng_bitpos    = RX_WAIT;
         end
         OP_DISARM: begin
            eng_listening = 1'b0;
         end
         default: begin
         end
      endcase
      s.line_out      = eng_level;
      s.tx_busy       = eng_sending;
      s.rx_armed      = eng_listening;
      s.overflow      = eng_lost;
      s.fill_level    = FILL_W'((int'(eng_head) + RING_DEPTH - int'(eng_tail)) % RING_DEPTH);
      s.rx_tick_count = eng_ticks;
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------
   function automatic void queue_cmd(logic [OP_W-1:0] op, logic line_in,
                                     logic [BYTE_W-1:0] tx_byte);
      uart_cmd c;
      c.op      = op;
      c.line_in = line_in;
      c.tx_byte = tx_byte;
      pending_q.push_back(c);
      queued_items++;
   endfunction

   // wire-side frame: optional idle-high ticks, start, data lsb first, stop
   function automatic void queue_rx_frame(logic [BYTE_W-1:0] data, logic stop_level);
      repeat ($urandom_range(0, 2)) queue_cmd(OP_TICK, 1'b1, rand_byte());
      queue_cmd(OP_TICK, 1'b0, rand_byte());
      for (int i = 0; i < BYTE_W; i++) queue_cmd(OP_TICK, data[i], rand_byte());
      queue_cmd(OP_TICK, stop_level, rand_byte());
   endfunction

   // load plus enough ticks to shift the frame and clear busy
   function automatic void queue_tx_frame(logic [BYTE_W-1:0] data);
      queue_cmd(OP_LOAD, rand_bit(), data);
      for (int i = 0; i <= FRAME_W; i++) begin
         if ($urandom_range(9) == 0) queue_cmd(OP_W'($urandom), rand_bit(), rand_byte());
         queue_cmd(OP_TICK, rand_bit(), rand_byte());
      end
   endfunction

   // more good frames than the ring holds, then drain a few
   function automatic void queue_overrun_burst();
      repeat (BURST_FRAMES) queue_rx_frame(rand_byte(), 1'b1);
      repeat ($urandom_range(1, 4)) queue_cmd(OP_READ, rand_bit(), rand_byte());
   endfunction

   function automatic void queue_directed();
      // tick while idle and unarmed, then read on an empty ring
      queue_cmd(OP_TICK, 1'b0, 8'h00);
      queue_cmd(OP_READ, 1'b1, 8'hFF);
      // unused op codes report state only
      for (int k = int'(OP_DISARM) + 1; k < (1 << OP_W); k++)
         queue_cmd(OP_W'(k), rand_bit(), rand_byte());
      queue_cmd(OP_DISARM, 1'b0, 8'h00);
      // load, then a load while busy that must be ignored
      queue_cmd(OP_LOAD, 1'b0, 8'hFF);
      queue_cmd(OP_LOAD, 1'b1, 8'h00);
      // arming during transmit, low line must not be sampled until frame ends
      queue_cmd(OP_ARM, 1'b0, 8'hFF);
      repeat (FRAME_W + 1) queue_cmd(OP_TICK, 1'b0, 8'h00);
      // first tick after the frame samples a start bit
      queue_cmd(OP_TICK, 1'b0, 8'hFF);
   endfunction

   function automatic void queue_random(int target);
      int                pick;
      logic [BYTE_W-1:0] data;
      while (queued_items < target) begin
         pick = $urandom_range(99);
         data = rand_byte();
         if ($urandom_range(7) == 0) data = rand_bit() ? '1 : '0;
         if (pick < 42)
            queue_rx_frame(data, $urandom_range(9) != 0);
         else if (pick < 56)
            queue_tx_frame(data);
         else if (pick < 74)
            repeat ($urandom_range(1, 3)) queue_cmd(OP_READ, rand_bit(), rand_byte());
         else if (pick < 78)
            queue_cmd(OP_ARM, rand_bit(), rand_byte());
         else if (pick < 81)
            queue_cmd(OP_DISARM, rand_bit(), rand_byte());
         else if (pick < 82)
            queue_overrun_burst();
         else
            queue_cmd(OP_W'($urandom), rand_bit(), rand_byte());
      end
   endfunction

   // ------------------------------------------------------------------------
   // driver: predicts on accept, offers the next transaction when free
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         reset_engine();
      end else begin
         if (req_valid && !req_stall)
            status_q.push_back(advance_engine(req_op, req_line_in, req_tx_byte));
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = pending_q.pop_front();
               req_valid   <= 1'b1;
               req_op      <= next_cmd.op;
               req_line_in <= next_cmd.line_in;
               req_tx_byte <= next_cmd.tx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: compares status transactions and drives the stall
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_status();
      uart_status want;
      if (status_q.size() == 0) begin
         $display("%0t: status transaction with nothing expected", $time);
         fail_count++;
      end else begin
         want = status_q.pop_front();
         check_field("line_out", want.line_out, rsp_line_out);
         check_field("tx_busy", want.tx_busy, rsp_tx_busy);
         check_field("rx_armed", want.rx_armed, rsp_rx_armed);
         check_field("read_valid", want.read_valid, rsp_read_valid);
         check_field("read_data", want.read_data, rsp_read_data);
         check_field("overflow", want.overflow, rsp_overflow);
         check_field("fill_level", want.fill_level, rsp_fill_level);
         check_field("rx_tick_count", want.rx_tick_count, rsp_rx_tick_count);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_status();
         // long hold-off on request, otherwise random stalls
         if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            rsp_stall   <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("half_duplex_uart_bit_engine test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // phase sequencing
   // ------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         @(negedge clock);
         send_idle_pct = (ph == 1) ? 56 : (ph == 3) ? 30 : 0;
         stall_pct     = (ph == 2) ? 56 : (ph == 3) ? 30 : 0;
         if (ph == 0) begin
            queue_directed();
            queue_overrun_burst();
         end
         queue_cmd(OP_ARM, rand_bit(), rand_byte());
         queue_random((ph + 1) * ITEM_TARGET / PHASES);
         // receiver holds off while the sender keeps offering
         if (ph == 0 || ph == 3) hold_asked = hold_asked + 1;
         // sender pauses until every result is back
         while (pending_q.size() > 0 || req_valid || status_q.size() > 0)
            @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("half_duplex_uart_bit_engine test passed");
      else
         $display("half_duplex_uart_bit_engine test failed");
      $finish;
   end

endmodule
